/* hdl/button_debounce_autorepeat_defines.svh */
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BDA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bda_pkg.sv */
package bda_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int CNT_W           = 8;
    localparam int LEVEL_W         = 4;
    localparam int INDEX_W         = 2;
    localparam int OUT_W           = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;

    localparam logic [CNT_W-1:0] DEBOUNCE_TOP_RST  = 8'd5;
    localparam logic [CNT_W-1:0] REPEAT_START_RST  = 8'd50;
    localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 8'd15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TOP  = 2'd0,
        REG_REPEAT_START  = 2'd1,
        REG_REPEAT_PERIOD = 2'd2
    } t_reg_index;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_TAKE = 1'b1
    } t_req_type;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_top;
        logic [CNT_W-1:0] repeat_start;
        logic [CNT_W-1:0] repeat_period;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic released;
        logic take;
    } t_ctrl;

    typedef struct packed {
        logic taken;
        logic pending;
        logic pressed;
    } t_stat;

endpackage

/* hdl/bda_cell.sv */
`include "button_debounce_autorepeat_defines.svh"

module bda_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bda_pkg::t_cfg  i_cfg,
    input  bda_pkg::t_ctrl i_ctrl,
    output bda_pkg::t_stat o_stat
);

    localparam logic [bda_pkg::CNT_W-1:0] CNT_MAX = '1;
    localparam logic [bda_pkg::CNT_W-1:0] CNT_ONE = bda_pkg::CNT_W'(1);

    logic [bda_pkg::CNT_W-1:0] r_integ, n_integ;
    logic [bda_pkg::CNT_W-1:0] r_hold, n_hold;
    logic [bda_pkg::CNT_W-1:0] r_rcnt, n_rcnt;
    logic                      r_pressed, n_pressed;
    logic                      r_mode, n_mode;
    logic                      r_pend, n_pend;

    logic [bda_pkg::CNT_W-1:0] integ_dn, integ_up, rcnt_inc, hold_inc;
    logic                      at_top, fire, start;

    assign integ_dn = (r_integ != '0) ? r_integ - CNT_ONE : r_integ;
    assign integ_up = (r_integ < i_cfg.debounce_top) ? r_integ + CNT_ONE : i_cfg.debounce_top;
    assign at_top   = (integ_up == i_cfg.debounce_top);
    assign rcnt_inc = (r_mode && (r_rcnt != CNT_MAX)) ? r_rcnt + CNT_ONE : r_rcnt;
    assign fire     = !r_pressed || (r_mode && (rcnt_inc >= i_cfg.repeat_period));
    assign hold_inc = (r_hold != CNT_MAX) ? r_hold + CNT_ONE : r_hold;
    assign start    = !r_mode && (hold_inc >= i_cfg.repeat_start);

    always_comb begin
        n_integ   = r_integ;
        n_hold    = r_hold;
        n_rcnt    = r_rcnt;
        n_pressed = r_pressed;
        n_mode    = r_mode;
        n_pend    = r_pend;
        priority if (i_ctrl.tick && i_ctrl.released) begin
            n_integ = integ_dn;
            if (integ_dn == '0) begin
                n_pressed = 1'b0;
                n_mode    = 1'b0;
                n_hold    = '0;
                n_rcnt    = '0;
            end
        end else if (i_ctrl.tick) begin
            n_integ = integ_up;
            if (at_top) begin
                n_rcnt = fire ? '0 : rcnt_inc;
                if (fire) begin
                    n_pressed = 1'b1;
                    n_pend    = 1'b1;
                end
                if (!r_mode) begin
                    n_hold = hold_inc;
                end
                if (start) begin
                    n_mode = 1'b1;
                    n_pend = 1'b1;
                end
            end
        end else if (i_ctrl.take) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ   <= '0;
            r_hold    <= '0;
            r_rcnt    <= '0;
            r_pressed <= 1'b0;
            r_mode    <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_integ   <= n_integ;
            r_hold    <= n_hold;
            r_rcnt    <= n_rcnt;
            r_pressed <= n_pressed;
            r_mode    <= n_mode;
            r_pend    <= n_pend;
        end
    end

    assign o_stat.taken   = i_ctrl.take && r_pend;
    assign o_stat.pending = n_pend;
    assign o_stat.pressed = n_pressed;

    `BDA_ASSERT_IMP(a_mode_needs_latch, r_mode, r_pressed, "repeat mode without pressed latch")
    `BDA_ASSERT_IMP(a_hold_idle_zero, !r_pressed, r_hold == '0, "hold count live while released")
    `BDA_ASSERT_NXT(a_pend_from_tick, !r_pend && !i_ctrl.tick, !r_pend, "event raised without a tick")

endmodule

/* hdl/button_debounce_autorepeat.sv */
// Channel  Dir  Handshake               Payload
// s        in   i_s_tvalid/o_s_tready   i_s_tdata, i_s_tuser (request)
// m        out  o_m_tvalid/i_m_tready   o_m_tdata (result, one per request)
// cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One transfer per cycle unless m stalls; input register, then result register.
// Per-button state updates in a single pass between the input and result registers.
// A stalled result register holds the input register, then o_s_tready drops.
// Synchronous active-low reset clears all button state and loads register defaults.
`include "button_debounce_autorepeat_defines.svh"

module button_debounce_autorepeat #(
    parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [3:0] button_levels, [5:4] take_button, [7:6] zero
    input  logic [bda_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // [0] req_type
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] event_taken, [4:1] pending_events, [8:5] pressed_mask, [15:9] zero
    output logic [bda_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bda_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bda_pkg::CNT_W-1:0]          i_cfg_data
);

    localparam int NV = (NUM_BUTTONS < bda_pkg::OUT_W) ? NUM_BUTTONS : bda_pkg::OUT_W;

    bda_pkg::t_cfg r_cfg;

    logic                              r_in_valid;
    logic                              r_req;
    logic [bda_pkg::LEVEL_W-1:0]       r_levels;
    logic [bda_pkg::INDEX_W-1:0]       r_index;

    logic                              r_out_valid;
    logic                              r_out_taken;
    logic [bda_pkg::OUT_W-1:0]         r_out_pend;
    logic [bda_pkg::OUT_W-1:0]         r_out_pressed;

    logic                              advance;
    logic                              is_tick;
    logic                              s_xfer;
    bda_pkg::t_stat                    stat [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]            taken_vec;
    logic [bda_pkg::OUT_W-1:0]         n_out_pend, n_out_pressed;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_top  <= bda_pkg::DEBOUNCE_TOP_RST;
            r_cfg.repeat_start  <= bda_pkg::REPEAT_START_RST;
            r_cfg.repeat_period <= bda_pkg::REPEAT_PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bda_pkg::REG_DEBOUNCE_TOP:  r_cfg.debounce_top  <= i_cfg_data;
                bda_pkg::REG_REPEAT_START:  r_cfg.repeat_start  <= i_cfg_data;
                bda_pkg::REG_REPEAT_PERIOD: r_cfg.repeat_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_in_valid || advance);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign is_tick    = (r_req == bda_pkg::REQ_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_req    <= i_s_tuser;
            r_levels <= i_s_tdata[bda_pkg::LEVEL_W-1:0];
            r_index  <= i_s_tdata[bda_pkg::LEVEL_W +: bda_pkg::INDEX_W];
        end
    end

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        bda_pkg::t_ctrl ctrl;
        logic           released;
        logic           sel;
        if (b < bda_pkg::LEVEL_W) begin : g_lvl
            assign released = r_levels[b];
            assign sel      = (r_index == bda_pkg::INDEX_W'(b));
        end else begin : g_nolvl
            assign released = 1'b0;
            assign sel      = 1'b0;
        end
        assign ctrl.tick     = advance && is_tick;
        assign ctrl.released = released;
        assign ctrl.take     = advance && !is_tick && sel;

        bda_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_ctrl  (ctrl),
            .o_stat  (stat[b])
        );
        assign taken_vec[b] = stat[b].taken;
    end

    always_comb begin
        n_out_pend    = '0;
        n_out_pressed = '0;
        for (int b = 0; b < NV; b++) begin
            n_out_pend[b]    = stat[b].pending;
            n_out_pressed[b] = stat[b].pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_taken   <= |taken_vec;
            r_out_pend    <= n_out_pend;
            r_out_pressed <= n_out_pressed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(bda_pkg::M_TDATA_W - 1 - 2 * bda_pkg::OUT_W){1'b0}},
                         r_out_pressed, r_out_pend, r_out_taken};

    `BDA_ASSERT_NXT(a_advance_fills_out, advance, r_out_valid, "result register not loaded")
    `BDA_ASSERT_NXT(a_tick_takes_none, advance && is_tick, !r_out_taken, "tick reported a taken event")
    `BDA_ASSERT_NXT(a_held_item_kept, r_in_valid && !advance, r_in_valid, "stalled request dropped")

endmodule
